[hdl/dpc_pkg.sv]
// dpc_pkg: shared types and constants of the bayer dead pixel correction block
// no dependencies; imported by the datapath modules, the top level and the checker
`default_nettype none

package dpc_pkg;

    // width and reset value of the dead threshold register
    localparam int unsigned THRESH_BITS         = 8;
    localparam logic [THRESH_BITS-1:0] DEAD_THRESHOLD_RESET = 8'd30;

    // number of same-color neighbors around the center
    localparam int unsigned NBR_COUNT = 8;

    // neighbor slots in the packed neighbor array
    localparam int unsigned NBR_N  = 0;
    localparam int unsigned NBR_S  = 1;
    localparam int unsigned NBR_W  = 2;
    localparam int unsigned NBR_E  = 3;
    localparam int unsigned NBR_NW = 4;
    localparam int unsigned NBR_NE = 5;
    localparam int unsigned NBR_SW = 6;
    localparam int unsigned NBR_SE = 7;

    // interpolation direction, in priority order for equal gradients
    typedef enum logic [1:0] {
        DIR_VERT  = 2'd0,
        DIR_HORIZ = 2'd1,
        DIR_MAIN  = 2'd2,
        DIR_ANTI  = 2'd3
    } dir_t;

endpackage : dpc_pkg

`default_nettype wire

[hdl/dpc_detect.sv]
// dpc_detect: dead pixel test of the center against its eight neighbors
// depends on dpc_pkg
`default_nettype none

module dpc_detect
    import dpc_pkg::*;
#(
    parameter int unsigned PIXEL_BITS = 10
) (
    input  wire logic [PIXEL_BITS-1:0]  center,
    input  wire logic [PIXEL_BITS-1:0]  nbr [NBR_COUNT],
    input  wire logic [THRESH_BITS-1:0] threshold,
    output logic                        dead
);

    logic [PIXEL_BITS-1:0] thresh_ext;
    logic [NBR_COUNT-1:0]  far;

    assign thresh_ext = PIXEL_BITS'(threshold);

    // each neighbor must differ by strictly more than the threshold
    always_comb begin
        for (int i = 0; i < NBR_COUNT; i++) begin
            if (nbr[i] > center) begin
                far[i] = (nbr[i] - center) > thresh_ext;
            end else begin
                far[i] = (center - nbr[i]) > thresh_ext;
            end
        end
    end

    assign dead = &far;

endmodule : dpc_detect

`default_nettype wire

[hdl/dpc_select.sv]
// dpc_select: directional gradients, smallest-gradient pick and rounded mean
// depends on dpc_pkg
`default_nettype none

module dpc_select
    import dpc_pkg::*;
#(
    parameter int unsigned PIXEL_BITS = 10
) (
    input  wire logic [PIXEL_BITS-1:0] center,
    input  wire logic [PIXEL_BITS-1:0] nbr [NBR_COUNT],
    output logic      [PIXEL_BITS-1:0] mean,
    output dir_t                       dir
);

    localparam int unsigned GRAD_BITS = PIXEL_BITS + 2;
    localparam int unsigned SUM_BITS  = PIXEL_BITS + 1;

    logic [PIXEL_BITS-1:0] first  [4];
    logic [PIXEL_BITS-1:0] second [4];
    logic [SUM_BITS-1:0]   pair_sum [4];
    logic [GRAD_BITS-1:0]  twice;
    logic [GRAD_BITS-1:0]  grad [4];
    logic [GRAD_BITS-1:0]  best_grad;
    logic [1:0]            best;
    logic [SUM_BITS-1:0]   rounded;

    // pairs in direction order
    always_comb begin
        first[DIR_VERT]   = nbr[NBR_N];
        second[DIR_VERT]  = nbr[NBR_S];
        first[DIR_HORIZ]  = nbr[NBR_W];
        second[DIR_HORIZ] = nbr[NBR_E];
        first[DIR_MAIN]   = nbr[NBR_NW];
        second[DIR_MAIN]  = nbr[NBR_SE];
        first[DIR_ANTI]   = nbr[NBR_NE];
        second[DIR_ANTI]  = nbr[NBR_SW];
    end

    assign twice = {1'b0, center, 1'b0};

    // second differences |2c - a - b|
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pair_sum[k] = SUM_BITS'(first[k]) + SUM_BITS'(second[k]);
            if (twice > GRAD_BITS'(pair_sum[k])) begin
                grad[k] = twice - GRAD_BITS'(pair_sum[k]);
            end else begin
                grad[k] = GRAD_BITS'(pair_sum[k]) - twice;
            end
        end
    end

    // strict compare keeps the earlier direction on ties
    always_comb begin
        best      = 2'd0;
        best_grad = grad[0];
        for (int k = 1; k < 4; k++) begin
            if (grad[k] < best_grad) begin
                best      = 2'(k);
                best_grad = grad[k];
            end
        end
    end

    // rounded mean of the chosen pair, always within pixel range
    assign rounded = pair_sum[best] + SUM_BITS'(1);
    assign mean    = rounded[SUM_BITS-1:1];
    assign dir     = dir_t'(best);

endmodule : dpc_select

`default_nettype wire

[hdl/bayer_dead_pixel_correction_top.sv]
// bayer_dead_pixel_correction_top: input register, correction datapath, result register
// depends on dpc_pkg, dpc_detect and dpc_select
`default_nettype none

// Bayer dead pixel correction. Each request carries a raw center pixel and its
// eight same-color neighbors at distance two; one result comes back per request.
// The block takes one request every clock unless the result side stalls, and handles
// each one in order: the request is captured in an input register, the dead test and the
// four-direction gradient pick run in one combinational pass, and the result is
// held in an output register. The input side keeps accepting while a result waits
// as long as the input register is free or moves on in the same cycle, so a stall
// on the result side backs up only after both registers are full. The threshold
// register (reset 30) is written through the cfg channel, which is always ready;
// write it only when no request is in flight.

module bayer_dead_pixel_correction_top
    import dpc_pkg::*;
#(
    parameter int unsigned PIXEL_BITS = 10
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [THRESH_BITS-1:0] cfg_data,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [PIXEL_BITS-1:0]  s_center_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_north_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_south_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_west_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_east_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_northwest_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_northeast_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_southwest_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_southeast_pixel,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [PIXEL_BITS-1:0]  m_corrected_pixel,
    output logic                        m_was_dead,
    output logic      [1:0]             m_chosen_direction
);

    logic [THRESH_BITS-1:0] thresh_reg;

    logic                  in_vld_reg;
    logic                  in_vld_next;
    logic [PIXEL_BITS-1:0] center_reg;
    logic [PIXEL_BITS-1:0] nbr_reg [NBR_COUNT];
    logic [PIXEL_BITS-1:0] nbr_in  [NBR_COUNT];

    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [PIXEL_BITS-1:0] pix_next;
    logic                  dead_reg;
    dir_t                  dir_reg;
    dir_t                  dir_next;

    logic                  dead;
    logic [PIXEL_BITS-1:0] mean;
    dir_t                  dir;
    logic                  out_free;
    logic                  in_take;

    // threshold register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= DEAD_THRESHOLD_RESET;
        end else if (cfg_valid) begin
            thresh_reg <= cfg_data;
        end
    end

    // handshake: each stage loads when empty or when it drains this cycle
    assign out_free     = !out_vld_reg || m_ready;
    assign s_ready      = !in_vld_reg || out_free;
    assign in_take      = s_valid && s_ready;
    assign in_vld_next  = s_ready ? s_valid : in_vld_reg;
    assign out_vld_next = out_free ? in_vld_reg : out_vld_reg;

    always_comb begin
        nbr_in[NBR_N]  = s_north_pixel;
        nbr_in[NBR_S]  = s_south_pixel;
        nbr_in[NBR_W]  = s_west_pixel;
        nbr_in[NBR_E]  = s_east_pixel;
        nbr_in[NBR_NW] = s_northwest_pixel;
        nbr_in[NBR_NE] = s_northeast_pixel;
        nbr_in[NBR_SW] = s_southwest_pixel;
        nbr_in[NBR_SE] = s_southeast_pixel;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            center_reg <= s_center_pixel;
            nbr_reg    <= nbr_in;
        end
    end

    // correction datapath
    dpc_detect #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_detect (
        .center    (center_reg),
        .nbr       (nbr_reg),
        .threshold (thresh_reg),
        .dead      (dead)
    );

    dpc_select #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_select (
        .center (center_reg),
        .nbr    (nbr_reg),
        .mean   (mean),
        .dir    (dir)
    );

    // live pixels pass through with direction fixed at vertical
    assign pix_next = dead ? mean : center_reg;
    assign dir_next = dead ? dir : DIR_VERT;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && in_vld_reg) begin
            pix_reg  <= pix_next;
            dead_reg <= dead;
            dir_reg  <= dir_next;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_corrected_pixel  = pix_reg;
    assign m_was_dead         = dead_reg;
    assign m_chosen_direction = dir_reg;

endmodule : bayer_dead_pixel_correction_top

`default_nettype wire

[hdl/dpc_checker.sv]
// dpc_port_props: port-level assertions for the dead pixel correction top level
// depends on dpc_pkg; bound to bayer_dead_pixel_correction_top
`default_nettype none

module dpc_port_props
    import dpc_pkg::*;
#(
    parameter int unsigned PIXEL_BITS = 10
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  cfg_ready,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [PIXEL_BITS-1:0] m_corrected_pixel,
    input wire logic                  m_was_dead,
    input wire logic [1:0]            m_chosen_direction
);

    // results are cleared by reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // input side only stalls when a result is held back
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("request refused without a blocked result");

    // a live pixel always reports the vertical direction
    a_live_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_was_dead) |-> (m_chosen_direction == DIR_VERT))
        else $error("direction set on a pixel that was not replaced");

    // held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_corrected_pixel)
            && $stable(m_was_dead) && $stable(m_chosen_direction)))
        else $error("stalled result changed");

    // configuration is never back-pressured
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule : dpc_port_props

bind bayer_dead_pixel_correction_top dpc_port_props #(
    .PIXEL_BITS (PIXEL_BITS)
) u_dpc_port_props (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .cfg_ready          (cfg_ready),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_corrected_pixel  (m_corrected_pixel),
    .m_was_dead         (m_was_dead),
    .m_chosen_direction (m_chosen_direction)
);

`default_nettype wire

[verif/dpc_checker.sv]
// dpc_checker: watches the request, result and threshold channels of the dead pixel block
// predicts each corrected pixel and compares it with what comes out; depends on dpc_pkg
`default_nettype none

module dpc_checker
    import dpc_pkg::*;
#(
    parameter int unsigned PIXEL_BITS = 10
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [THRESH_BITS-1:0] cfg_data,

    input  wire logic                   s_valid,
    input  wire logic                   s_ready,
    input  wire logic [PIXEL_BITS-1:0]  s_center_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_north_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_south_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_west_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_east_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_northwest_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_northeast_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_southwest_pixel,
    input  wire logic [PIXEL_BITS-1:0]  s_southeast_pixel,

    input  wire logic                   m_valid,
    input  wire logic                   m_ready,
    input  wire logic [PIXEL_BITS-1:0]  m_corrected_pixel,
    input  wire logic                   m_was_dead,
    input  wire logic [1:0]             m_chosen_direction,

    output int                          mismatch_count,
    output int                          pixels_in_flight
);

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef logic [PIXEL_BITS+1:0] wide_t;
    typedef pix_t nbr_t [NBR_COUNT];

    typedef struct packed {
        pix_t corrected;
        logic was_dead;
        dir_t direction;
    } pixel_result_t;

    // neighbor slots of each direction, in priority order
    localparam int unsigned PAIR_FIRST  [4] = '{NBR_N, NBR_W, NBR_NW, NBR_NE};
    localparam int unsigned PAIR_SECOND [4] = '{NBR_S, NBR_E, NBR_SE, NBR_SW};

    logic [THRESH_BITS-1:0] dead_threshold;
    pixel_result_t          expected_pixels [$];
    pixel_result_t          oldest;
    nbr_t                   neighbors;
    int                     mismatches = 0;

    assign mismatch_count = mismatches;

    assign neighbors[NBR_N]  = s_north_pixel;
    assign neighbors[NBR_S]  = s_south_pixel;
    assign neighbors[NBR_W]  = s_west_pixel;
    assign neighbors[NBR_E]  = s_east_pixel;
    assign neighbors[NBR_NW] = s_northwest_pixel;
    assign neighbors[NBR_NE] = s_northeast_pixel;
    assign neighbors[NBR_SW] = s_southwest_pixel;
    assign neighbors[NBR_SE] = s_southeast_pixel;

    function automatic wide_t abs_diff(input wide_t a, input wide_t b);
        return (a > b) ? a - b : b - a;
    endfunction

    // dead test, then the pair with the flattest second difference
    function automatic pixel_result_t correct_pixel(input pix_t ctr, input nbr_t nbr,
                                                    input logic [THRESH_BITS-1:0] thr);
        pixel_result_t res;
        logic          dead;
        wide_t         pair_sum;
        wide_t         grad;
        wide_t         best_grad;
        wide_t         best_sum;
        dir_t          best_dir;
        dead = 1'b1;
        for (int i = 0; i < NBR_COUNT; i++) begin
            if (abs_diff(wide_t'(nbr[i]), wide_t'(ctr)) <= wide_t'(thr))
                dead = 1'b0;
        end
        res.corrected = ctr;
        res.was_dead  = 1'b0;
        res.direction = DIR_VERT;
        if (!dead)
            return res;
        best_grad = '1;
        best_sum  = '0;
        best_dir  = DIR_VERT;
        // strict compare keeps the earlier direction on a tie
        for (int k = DIR_VERT; k <= DIR_ANTI; k++) begin
            pair_sum = wide_t'(nbr[PAIR_FIRST[k]]) + wide_t'(nbr[PAIR_SECOND[k]]);
            grad     = abs_diff(wide_t'({ctr, 1'b0}), pair_sum);
            if (grad < best_grad) begin
                best_grad = grad;
                best_sum  = pair_sum;
                best_dir  = dir_t'(k);
            end
        end
        res.corrected = pix_t'((best_sum + 1'b1) >> 1);
        res.was_dead  = 1'b1;
        res.direction = best_dir;
        return res;
    endfunction

    // track the threshold, queue predictions, compare results in order
    always @(posedge aclk) begin
        if (!aresetn) begin
            dead_threshold <= DEAD_THRESHOLD_RESET;
            expected_pixels.delete();
            pixels_in_flight <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                dead_threshold <= cfg_data;
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request pending, corrected_pixel %0d",
                             $time, m_corrected_pixel);
                end else begin
                    oldest = expected_pixels.pop_front();
                    if (m_corrected_pixel !== oldest.corrected) begin
                        mismatches++;
                        $display("%0t: corrected_pixel expected %0d, got %0d",
                                 $time, oldest.corrected, m_corrected_pixel);
                    end
                    if (m_was_dead !== oldest.was_dead) begin
                        mismatches++;
                        $display("%0t: was_dead expected %0d, got %0d",
                                 $time, oldest.was_dead, m_was_dead);
                    end
                    if (m_chosen_direction !== oldest.direction) begin
                        mismatches++;
                        $display("%0t: chosen_direction expected %0d, got %0d",
                                 $time, oldest.direction, m_chosen_direction);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_pixels.insert(expected_pixels.size(),
                                       correct_pixel(s_center_pixel, neighbors,
                                                     dead_threshold));
            pixels_in_flight <= expected_pixels.size();
        end
    end

endmodule : dpc_checker

`default_nettype wire

[verif/tb.sv]
// tb: request and result stimulus with random gaps, threshold writes and the final verdict
// depends on dpc_pkg, bayer_dead_pixel_correction_top and dpc_checker
`default_nettype none

module tb;
    import dpc_pkg::*;

    localparam int unsigned PB              = 10;
    localparam int          PIX_MAX         = (1 << PB) - 1;
    localparam int          RESET_CYCLES    = 7;
    localparam int          DRAIN_CYCLES    = 6;
    localparam int          PRESSURE_CYCLES = 400;
    localparam int          WATCHDOG_LIMIT  = 4000;
    localparam int          PHASE_COUNT     = 8;
    localparam int          PHASE_ITEMS     = 235;

    localparam int unsigned PAIR_FIRST  [4] = '{NBR_N, NBR_W, NBR_NW, NBR_NE};
    localparam int unsigned PAIR_SECOND [4] = '{NBR_S, NBR_E, NBR_SE, NBR_SW};

    typedef logic [PB-1:0] pix_t;
    typedef pix_t nbr_t [NBR_COUNT];

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [THRESH_BITS-1:0] cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    pix_t                   s_center_pixel;
    pix_t                   s_north_pixel;
    pix_t                   s_south_pixel;
    pix_t                   s_west_pixel;
    pix_t                   s_east_pixel;
    pix_t                   s_northwest_pixel;
    pix_t                   s_northeast_pixel;
    pix_t                   s_southwest_pixel;
    pix_t                   s_southeast_pixel;
    logic                   m_valid;
    logic                   m_ready;
    pix_t                   m_corrected_pixel;
    logic                   m_was_dead;
    logic [1:0]             m_chosen_direction;

    int                     mismatch_count;
    int                     pixels_in_flight;
    int                     idle_cycles = 0;
    bit                     quiet = 1'b0;
    bit                     hold_off_req = 1'b0;
    logic [THRESH_BITS-1:0] threshold_now = DEAD_THRESHOLD_RESET;

    always #5 aclk = ~aclk;

    bayer_dead_pixel_correction_top #(
        .PIXEL_BITS (PB)
    ) i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_center_pixel     (s_center_pixel),
        .s_north_pixel      (s_north_pixel),
        .s_south_pixel      (s_south_pixel),
        .s_west_pixel       (s_west_pixel),
        .s_east_pixel       (s_east_pixel),
        .s_northwest_pixel  (s_northwest_pixel),
        .s_northeast_pixel  (s_northeast_pixel),
        .s_southwest_pixel  (s_southwest_pixel),
        .s_southeast_pixel  (s_southeast_pixel),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_corrected_pixel  (m_corrected_pixel),
        .m_was_dead         (m_was_dead),
        .m_chosen_direction (m_chosen_direction)
    );

    dpc_checker #(
        .PIXEL_BITS (PB)
    ) i_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_center_pixel     (s_center_pixel),
        .s_north_pixel      (s_north_pixel),
        .s_south_pixel      (s_south_pixel),
        .s_west_pixel       (s_west_pixel),
        .s_east_pixel       (s_east_pixel),
        .s_northwest_pixel  (s_northwest_pixel),
        .s_northeast_pixel  (s_northeast_pixel),
        .s_southwest_pixel  (s_southwest_pixel),
        .s_southeast_pixel  (s_southeast_pixel),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_corrected_pixel  (m_corrected_pixel),
        .m_was_dead         (m_was_dead),
        .m_chosen_direction (m_chosen_direction),
        .mismatch_count     (mismatch_count),
        .pixels_in_flight   (pixels_in_flight)
    );

    // mostly back to back, sometimes a short gap, rarely a long pause; none when quiet
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic pix_t clip_pixel(input int v);
        if (v < 0)
            return '0;
        if (v > PIX_MAX)
            return pix_t'(PIX_MAX);
        return pix_t'(v);
    endfunction

    function automatic int jitter(input int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // one random request, shaped so that most of them exercise the dead path
    task automatic make_pixel(input int thr, output pix_t ctr, output nbr_t nb);
        int roll;
        int base;
        int spread;
        int reach;
        int odd_slot;
        int src;
        int dst;
        bit neg;
        roll   = $urandom_range(0, 99);
        base   = $urandom_range(0, PIX_MAX);
        spread = $urandom_range(0, 60);
        if (roll < 15) begin
            // unrelated values on every field
            ctr = pix_t'($urandom_range(0, PIX_MAX));
            for (int i = 0; i < NBR_COUNT; i++)
                nb[i] = pix_t'($urandom_range(0, PIX_MAX));
        end else if (roll < 35) begin
            // smooth patch, center within the neighbor spread
            spread = $urandom_range(0, thr);
            for (int i = 0; i < NBR_COUNT; i++)
                nb[i] = clip_pixel(base + jitter(spread));
            ctr = clip_pixel(base + jitter(spread));
        end else if (roll < 80) begin
            // isolated hot or dark center on a flat patch
            for (int i = 0; i < NBR_COUNT; i++)
                nb[i] = clip_pixel(base + jitter(spread));
            reach = thr + spread + 1 + int'($urandom_range(0, 300));
            ctr   = clip_pixel(base >= PIX_MAX / 2 ? base - reach : base + reach);
            // copy one pair onto another direction so the gradients tie
            if ($urandom_range(0, 99) < 40) begin
                src = $urandom_range(0, 3);
                dst = $urandom_range(0, 3);
                nb[PAIR_FIRST[dst]]  = nb[PAIR_FIRST[src]];
                nb[PAIR_SECOND[dst]] = nb[PAIR_SECOND[src]];
            end
        end else begin
            // neighbors just past the threshold, one of them on it or one above
            ctr      = pix_t'($urandom_range(300, 700));
            odd_slot = $urandom_range(0, NBR_COUNT - 1);
            for (int i = 0; i < NBR_COUNT; i++) begin
                reach = (i == odd_slot) ? thr + int'($urandom_range(0, 1))
                                        : thr + 1 + int'($urandom_range(0, 20));
                neg   = 1'($urandom_range(0, 1));
                nb[i] = clip_pixel(neg ? int'(ctr) - reach : int'(ctr) + reach);
            end
        end
    endtask

    // offer one request and hold it until the block takes it
    task automatic offer_pixel(input pix_t ctr, input nbr_t nb);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_center_pixel    <= ctr;
        s_north_pixel     <= nb[NBR_N];
        s_south_pixel     <= nb[NBR_S];
        s_west_pixel      <= nb[NBR_W];
        s_east_pixel      <= nb[NBR_E];
        s_northwest_pixel <= nb[NBR_NW];
        s_northeast_pixel <= nb[NBR_NE];
        s_southwest_pixel <= nb[NBR_SW];
        s_southeast_pixel <= nb[NBR_SE];
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic offer_case(input int c, input int n, input int s, input int w, input int e,
                              input int nw, input int ne, input int sw, input int se);
        nbr_t nb;
        nb[NBR_N]  = pix_t'(n);
        nb[NBR_S]  = pix_t'(s);
        nb[NBR_W]  = pix_t'(w);
        nb[NBR_E]  = pix_t'(e);
        nb[NBR_NW] = pix_t'(nw);
        nb[NBR_NE] = pix_t'(ne);
        nb[NBR_SW] = pix_t'(sw);
        nb[NBR_SE] = pix_t'(se);
        offer_pixel(pix_t'(c), nb);
    endtask

    // stop offering, wait out every pending result and the pipeline tail
    task automatic drain_block();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pixels_in_flight != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [THRESH_BITS-1:0] thr);
        cfg_valid <= 1'b1;
        cfg_data  <= thr;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid     <= 1'b0;
        threshold_now = thr;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = PRESSURE_CYCLES;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // reset, directed requests, then random phases at several thresholds
    initial begin
        pix_t ctr;
        nbr_t nb;
        int   thr;
        aresetn           <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_data          <= '0;
        s_valid           <= 1'b0;
        s_center_pixel    <= '0;
        s_north_pixel     <= '0;
        s_south_pixel     <= '0;
        s_west_pixel      <= '0;
        s_east_pixel      <= '0;
        s_northwest_pixel <= '0;
        s_northeast_pixel <= '0;
        s_southwest_pixel <= '0;
        s_southeast_pixel <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // threshold at its reset value
        offer_case(0, 0, 0, 0, 0, 0, 0, 0, 0);
        offer_case(1023, 0, 0, 0, 0, 0, 0, 0, 0);
        offer_case(0, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023);
        offer_case(100, 130, 130, 130, 130, 130, 130, 130, 130);
        offer_case(100, 131, 131, 131, 131, 131, 131, 131, 131);
        offer_case(100, 131, 131, 131, 131, 131, 131, 131, 70);
        offer_case(100, 69, 131, 69, 131, 69, 131, 69, 131);
        offer_case(500, 0, 0, 100, 100, 50, 0, 0, 50);
        offer_case(500, 0, 0, 0, 0, 200, 0, 0, 201);
        offer_case(500, 0, 0, 0, 0, 0, 300, 301, 0);
        offer_case(500, 0, 0, 100, 100, 100, 0, 0, 100);
        offer_case(500, 0, 0, 0, 0, 100, 99, 101, 100);
        offer_case(100, 600, 600, 300, 0, 0, 0, 0, 0);
        offer_case(0, 1023, 1023, 1022, 1023, 1023, 1023, 1023, 1023);
        offer_case(1000, 3, 4, 0, 0, 0, 0, 0, 0);
        offer_case(512, 0, 0, 0, 0, 0, 0, 0, 500);
        offer_case(341, 682, 682, 682, 682, 682, 682, 682, 682);
        drain_block();

        // widest threshold
        write_threshold(8'd255);
        offer_case(0, 256, 256, 256, 256, 256, 256, 256, 256);
        offer_case(0, 255, 255, 255, 255, 255, 255, 255, 255);
        offer_case(1023, 768, 768, 768, 768, 768, 768, 768, 768);
        drain_block();

        // zero threshold: any difference at all counts
        write_threshold(8'd0);
        offer_case(5, 5, 5, 5, 5, 5, 5, 5, 5);
        offer_case(5, 4, 6, 4, 6, 4, 6, 4, 6);
        drain_block();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:       thr = 0;
                1:       thr = 255;
                2:       thr = 1;
                3:       thr = 254;
                7:       thr = int'(DEAD_THRESHOLD_RESET);
                default: thr = $urandom_range(0, 255);
            endcase
            write_threshold(THRESH_BITS'(thr));
            quiet = (phase == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long result stall mid phase so the block backs up
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    hold_off_req = 1'b1;
                make_pixel(int'(threshold_now), ctr, nb);
                offer_pixel(ctr, nb);
            end
            drain_block();
        end

        if (mismatch_count == 0 && pixels_in_flight == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule : tb

`default_nettype wire
